FILE: rtl/mbe_pkg.sv
// mbe_pkg: shared types and constants for the escape-time unit.
// No dependencies.
package mbe_pkg;

    localparam int unsigned MaxDim  = 4096;
    localparam int unsigned IdxW    = 12;
    localparam int unsigned QW      = 32;
    localparam int unsigned PW      = 64;
    localparam int unsigned CntW    = 16;
    localparam int unsigned NCells  = 4;

    localparam logic [2:0] REG_LIMIT = 3'd0;
    localparam logic [2:0] REG_XORG  = 3'd1;
    localparam logic [2:0] REG_YORG  = 3'd2;
    localparam logic [2:0] REG_XSTEP = 3'd3;
    localparam logic [2:0] REG_YSTEP = 3'd4;

    localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};

    typedef enum logic [1:0] {
        t_ST_IDLE,
        t_ST_SETUP,
        t_ST_RUN
    } t_state;

    // word travelling down the chain of cells
    typedef struct packed {
        logic                   vld;
        logic                   esc;
        logic [CntW-1:0]        k;
        logic signed [QW-1:0]   zre;
        logic signed [QW-1:0]   zim;
        logic signed [PW-1:0]   r2;
        logic signed [PW-1:0]   i2;
        logic signed [PW-1:0]   ri;
    } t_word;

    // saturate a 65-bit signed value to Q4.28
    function automatic logic signed [QW-1:0] sat_q(input logic signed [PW:0] v);
        if (v < 65'(signed'(QMin))) return QMin;
        if (v > 65'(signed'(QMax))) return QMax;
        return v[QW-1:0];
    endfunction

endpackage

FILE: rtl/mbe_cell.sv
// mbe_cell: one stage of the iteration ring; forms products or tests and updates, as set by i_mul.
// Depends on mbe_pkg.
module mbe_cell import mbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_mul,     // 1: form products, 0: test and update
    input  logic [CntW-1:0]       i_limit,
    input  logic signed [QW-1:0]  i_cre,
    input  logic signed [QW-1:0]  i_cim,
    input  t_word                 i_word,
    output t_word                 o_word
);
    t_word r_word, n_word;
    logic [PW:0]          mag;
    logic signed [PW:0]   dre;
    logic signed [PW:0]   dim;

    always_comb begin
        n_word = i_word;
        mag = {1'b0, i_word.r2} + {1'b0, i_word.i2};
        dre = 65'(signed'(i_word.r2 - i_word.i2) >>> 28) + 65'(i_cre);
        dim = 65'(i_word.ri >>> 27) + 65'(i_cim);
        if (i_word.vld && !i_word.esc) begin
            if (i_mul) begin
                // one multiplier per product, registered before use
                n_word.r2 = i_word.zre * i_word.zre;
                n_word.i2 = i_word.zim * i_word.zim;
                n_word.ri = i_word.zre * i_word.zim;
            end else if (i_word.k >= i_limit) begin
                n_word.esc = 1'b1;
            end else if (mag > 65'(64'd1 << 58)) begin
                n_word.esc = 1'b1;
            end else begin
                n_word.zre = sat_q(dre);
                n_word.zim = sat_q(dim);
                n_word.k   = i_word.k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else begin
            r_word.vld <= n_word.vld;
        end
        r_word.esc <= n_word.esc;
        r_word.k   <= n_word.k;
        r_word.zre <= n_word.zre;
        r_word.zim <= n_word.zim;
        r_word.r2  <= n_word.r2;
        r_word.i2  <= n_word.i2;
        r_word.ri  <= n_word.ri;
    end

    assign o_word = r_word;
endmodule

FILE: rtl/mandelbrot_escape_time_unit.sv
// Escape-time unit: one pixel at a time through a ring of NCells cells.
// Setup multiplies, then adds and saturates, then injects the word; each
// iteration passes a product cell, then an update cell. One pixel in flight,
// busy high until the strobe cycle, in which a new word can be taken. Result
// strobes for one cycle; the receiver cannot stall.
// Synchronous active-low reset restores the register defaults and idles.
module mandelbrot_escape_time_unit import mbe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IdxW-1:0]  i_column,
    input  logic [IdxW-1:0]  i_row,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output logic             o_valid,
    output logic [CntW-1:0]  o_escape_count
);
    t_state r_state, n_state;
    logic [CntW-1:0]       r_limit;
    logic signed [QW-1:0]  r_xorg, r_yorg;
    logic [30:0]           r_xstep, r_ystep;
    logic [IdxW-1:0]       r_col, r_row;
    logic [IdxW+30:0]      r_px, r_py;
    logic signed [QW-1:0]  r_cre, r_cim;
    logic [1:0]            r_phase;
    logic                  r_out;
    logic [CntW-1:0]       r_cnt;
    logic                  inject;
    t_word                 seed;
    t_word                 ring_in;
    t_word                 w [NCells+1];

    assign o_cfg_ready = 1'b1;
    assign busy = (r_state != t_ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 16'd100;
            r_xorg  <= -32'sd536870912;
            r_yorg  <= -32'sd402653184;
            r_xstep <= 31'd786432;
            r_ystep <= 31'd786432;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LIMIT: r_limit <= i_cfg_data[15:0];
                REG_XORG:  r_xorg  <= i_cfg_data;
                REG_YORG:  r_yorg  <= i_cfg_data;
                REG_XSTEP: r_xstep <= i_cfg_data[30:0];
                REG_YSTEP: r_ystep <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // control FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_ST_IDLE;
        else          r_state <= n_state;
    end

    logic done;
    assign done = w[NCells].vld && w[NCells].esc;

    always_comb begin
        n_state = r_state;
        inject = 1'b0;
        case (r_state)
            t_ST_IDLE:  if (start) n_state = t_ST_SETUP;
            t_ST_SETUP: if (r_phase == 2'd2) begin
                n_state = t_ST_RUN;
                inject = 1'b1;
            end
            t_ST_RUN:   if (done) n_state = t_ST_IDLE;
            default:    n_state = t_ST_IDLE;
        endcase
    end

    // point setup: clamp-free (12-bit index < MaxDim), multiply, add, saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (r_state == t_ST_SETUP) begin
            r_phase <= r_phase + 2'd1;
        end else begin
            r_phase <= 2'd0;
        end
        if (r_state == t_ST_IDLE && start) begin
            r_col <= i_column;
            r_row <= i_row;
        end
        if (r_state == t_ST_SETUP && r_phase == 2'd0) begin
            r_px <= r_col * r_xstep;
            r_py <= r_row * r_ystep;
        end
        if (r_state == t_ST_SETUP && r_phase == 2'd1) begin
            r_cre <= sat_q(65'(r_xorg) + 65'(signed'({1'b0, r_px})));
            r_cim <= sat_q(65'(r_yorg) + 65'(signed'({1'b0, r_py})));
        end
    end

    // ring: the last cell feeds back into the first
    always_comb begin
        seed = '0;
        seed.vld = 1'b1;
        seed.zre = r_cre;
        seed.zim = r_cim;
        if (inject)                            ring_in = seed;
        else if (r_state == t_ST_RUN && !done) ring_in = w[NCells];
        else                                   ring_in = '0;
    end

    assign w[0] = ring_in;

    // even cells form products, odd cells test and update
    genvar g;
    generate
        for (g = 0; g < NCells; g++) begin : g_cell
            mbe_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_mul   ((g % 2) == 0),
                .i_limit (r_limit),
                .i_cre   (r_cre),
                .i_cim   (r_cim),
                .i_word  (w[g]),
                .o_word  (w[g+1])
            );
        end
    endgenerate

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= 1'b0;
        end else begin
            r_out <= (r_state == t_ST_RUN) && done;
        end
        if (done) r_cnt <= w[NCells].k;
    end

    assign o_valid        = r_out;
    assign o_escape_count = r_cnt;
endmodule

FILE: rtl/mbe_checker.sv
// mbe_checker: port-level assertions for the escape-time unit.
// Depends on mbe_pkg; bound to mandelbrot_escape_time_unit.
module mbe_checker import mbe_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_valid,
    input logic [CntW-1:0] o_escape_count
);
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accept without busy");
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe longer than one cycle");
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_valid) else $error("result too early");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("busy with result");
    a_count_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_escape_count)) else $error("unknown count");
endmodule

bind mandelbrot_escape_time_unit mbe_checker u_mbe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_escape_count (o_escape_count)
);
